// ===== sv/fenwick_range_add_point_query_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the range add and point query core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FENWICK_RANGE_ADD_POINT_QUERY_CORE_ASSERT_SVH
`define FENWICK_RANGE_ADD_POINT_QUERY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRAPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frapq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FRAPQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frapq assertion failed");

`endif

// ===== sv/frapq_pkg.sv =====
// ----------------------------------------------------------------------------
// frapq_pkg
// Types, constants and helper functions of the range add and point query core.
// ----------------------------------------------------------------------------
package frapq_pkg;

	localparam int MAX_ELEMENTS = 65536;
	localparam int TREE_AW      = $clog2(MAX_ELEMENTS);
	localparam int IDX_W        = TREE_AW + 2;

	localparam int MODE_W     = 2;
	localparam int POS_W      = 17;
	localparam int VAL_W      = 32;
	localparam int SUM_W      = 64;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	localparam logic REG_SIZE_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_UP_FIRST,
		ST_RIGHT_START,
		ST_UP_LAST,
		ST_QUERY,
		ST_OUT
	} ctl_state_t;

	typedef struct packed {
		logic take;
		logic clr_step;
		logic start_load;
		logic start_left;
		logic start_right;
		logic start_query;
		logic up_step;
		logic down_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              load_ok;
		logic              left_ok;
		logic              right_ok;
		logic              up_done;
		logic              down_done;
		logic              clr_last;
	} status_t;

	function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] i);
		low_bit = i & (~i + IDX_W'(1));
	endfunction

endpackage

// ===== sv/frapq_if.sv =====
// ----------------------------------------------------------------------------
// frapq_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface frapq_in_if;
	logic                                   valid;
	logic                                   ready;
	logic        [frapq_pkg::MODE_W-1:0]    mode;
	logic        [frapq_pkg::POS_W-1:0]     left;
	logic        [frapq_pkg::POS_W-1:0]     right;
	logic signed [frapq_pkg::VAL_W-1:0]     value;

	modport source (output valid, output mode, output left, output right, output value,
		input ready);
	modport sink (input valid, input mode, input left, input right, input value,
		output ready);
endinterface

interface frapq_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [frapq_pkg::SUM_W-1:0]     element_value;

	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

// ===== sv/fenwick_range_add_point_query_core.sv =====
// ----------------------------------------------------------------------------
// fenwick_range_add_point_query_core
// Range add and point query over a binary indexed tree of differences.
// ----------------------------------------------------------------------------
// Input items arrive on in_ch: mode 0 loads the next initial element, mode 1
// adds value over left..right, mode 2 queries the element at left. Only a
// query produces a result item on out_ch, carrying element_value.
// Items are handled one at a time. On a walk that updates the tree, the memory
// reads the next entry while it writes back the last one.
// After reset a clearing pass zeroes all 65536 tree entries, one per cycle;
// in_ch.ready stays low during the pass, while register writes are taken.
// The result sits in an output register, so a stalled receiver holds only the
// next query at its end; loads and adds keep flowing.
// The size_in_use register at address 0 must be written only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fenwick_range_add_point_query_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	frapq_in_if.sink                               in_ch,
	frapq_out_if.source                            out_ch,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [frapq_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [frapq_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [frapq_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                   pready
);

	`include "fenwick_range_add_point_query_core_assert.svh"

	frapq_pkg::cmd_t                 cmd;
	frapq_pkg::status_t              status;
	logic [frapq_pkg::POS_W-1:0]     size_q;
	logic [frapq_pkg::POS_W-1:0]     size_eff;
	logic                            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == frapq_pkg::REG_SIZE_IN_USE);
	assign prdata  = reg_sel ? frapq_pkg::CFG_DATA_W'(size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= frapq_pkg::POS_W'(frapq_pkg::MAX_ELEMENTS);
		end else if (psel && penable && pwrite && reg_sel) begin
			size_q <= pwdata[frapq_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		if (size_q == '0) begin
			size_eff = frapq_pkg::POS_W'(1);
		end else if (size_q > frapq_pkg::POS_W'(frapq_pkg::MAX_ELEMENTS)) begin
			size_eff = frapq_pkg::POS_W'(frapq_pkg::MAX_ELEMENTS);
		end else begin
			size_eff = size_q;
		end
	end

	frapq_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.status    (status),
		.cmd       (cmd)
	);

	frapq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.size_eff  (size_eff),
		.in_mode   (in_ch.mode),
		.in_left   (in_ch.left),
		.in_right  (in_ch.right),
		.in_value  (in_ch.value),
		.out_value (out_ch.element_value)
	);

	`FRAPQ_ASSERT_IMP(a_no_result_overwrite, cmd.out_load, !out_ch.valid || out_ch.ready)
	`FRAPQ_ASSERT_NXT(a_one_item_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)
	`FRAPQ_ASSERT_IMP(a_single_walk_start, 1'b1,
		$onehot0({cmd.start_load, cmd.start_left, cmd.start_right, cmd.start_query}))
	`FRAPQ_ASSERT_IMP(a_no_accept_while_clearing, cmd.clr_step, !in_ch.ready)

endmodule

// ===== sv/frapq_ctl.sv =====
// ----------------------------------------------------------------------------
// frapq_ctl
// Controller that sequences the clearing pass, tree walks and result hand-off.
// ----------------------------------------------------------------------------
module frapq_ctl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  frapq_pkg::status_t   status,
	output frapq_pkg::cmd_t      cmd
);

	frapq_pkg::ctl_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frapq_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			frapq_pkg::ST_CLEAR: begin
				if (status.clr_last) state_d = frapq_pkg::ST_IDLE;
			end
			frapq_pkg::ST_IDLE: begin
				if (in_valid) state_d = frapq_pkg::ST_DISPATCH;
			end
			frapq_pkg::ST_DISPATCH: begin
				case (status.mode)
					frapq_pkg::MODE_LOAD: begin
						state_d = status.load_ok ? frapq_pkg::ST_UP_LAST : frapq_pkg::ST_IDLE;
					end
					frapq_pkg::MODE_ADD: begin
						state_d = status.left_ok ? frapq_pkg::ST_UP_FIRST
							: frapq_pkg::ST_RIGHT_START;
					end
					frapq_pkg::MODE_QUERY: begin
						state_d = frapq_pkg::ST_QUERY;
					end
					default: begin
						state_d = frapq_pkg::ST_IDLE;
					end
				endcase
			end
			frapq_pkg::ST_UP_FIRST: begin
				if (status.up_done) state_d = frapq_pkg::ST_RIGHT_START;
			end
			frapq_pkg::ST_RIGHT_START: begin
				state_d = status.right_ok ? frapq_pkg::ST_UP_LAST : frapq_pkg::ST_IDLE;
			end
			frapq_pkg::ST_UP_LAST: begin
				if (status.up_done) state_d = frapq_pkg::ST_IDLE;
			end
			frapq_pkg::ST_QUERY: begin
				if (status.down_done) state_d = frapq_pkg::ST_OUT;
			end
			frapq_pkg::ST_OUT: begin
				if (slot_free) state_d = frapq_pkg::ST_IDLE;
			end
			default: begin
				state_d = frapq_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		in_ready    = (state_q == frapq_pkg::ST_IDLE);
		out_valid   = out_valid_q;
		cmd.take    = (state_q == frapq_pkg::ST_IDLE) && in_valid;
		cmd.clr_step = (state_q == frapq_pkg::ST_CLEAR);
		cmd.start_load = (state_q == frapq_pkg::ST_DISPATCH)
			&& (status.mode == frapq_pkg::MODE_LOAD) && status.load_ok;
		cmd.start_left = (state_q == frapq_pkg::ST_DISPATCH)
			&& (status.mode == frapq_pkg::MODE_ADD) && status.left_ok;
		cmd.start_query = (state_q == frapq_pkg::ST_DISPATCH)
			&& (status.mode == frapq_pkg::MODE_QUERY);
		cmd.start_right = (state_q == frapq_pkg::ST_RIGHT_START) && status.right_ok;
		cmd.up_step   = (state_q == frapq_pkg::ST_UP_FIRST) || (state_q == frapq_pkg::ST_UP_LAST);
		cmd.down_step = (state_q == frapq_pkg::ST_QUERY);
		cmd.out_load  = (state_q == frapq_pkg::ST_OUT) && slot_free;
	end

endmodule

// ===== sv/frapq_dp.sv =====
// ----------------------------------------------------------------------------
// frapq_dp
// Datapath holding the tree memory, walk index, accumulator and load state.
// ----------------------------------------------------------------------------
module frapq_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  frapq_pkg::cmd_t                       cmd,
	output frapq_pkg::status_t                    status,
	input  logic [frapq_pkg::POS_W-1:0]           size_eff,
	input  logic [frapq_pkg::MODE_W-1:0]          in_mode,
	input  logic [frapq_pkg::POS_W-1:0]           in_left,
	input  logic [frapq_pkg::POS_W-1:0]           in_right,
	input  logic signed [frapq_pkg::VAL_W-1:0]    in_value,
	output logic signed [frapq_pkg::SUM_W-1:0]    out_value
);

	logic [frapq_pkg::SUM_W-1:0]          tree_mem [frapq_pkg::MAX_ELEMENTS];

	logic [frapq_pkg::MODE_W-1:0]         mode_q;
	logic [frapq_pkg::POS_W-1:0]          left_q;
	logic [frapq_pkg::POS_W-1:0]          right_q;
	logic signed [frapq_pkg::VAL_W-1:0]   value_q;
	logic [frapq_pkg::POS_W-1:0]          load_pos_q;
	logic signed [frapq_pkg::VAL_W-1:0]   prev_q;
	logic [frapq_pkg::IDX_W-1:0]          idx_q;
	logic [frapq_pkg::SUM_W-1:0]          delta_q;
	logic [frapq_pkg::SUM_W-1:0]          acc_q;
	logic [frapq_pkg::SUM_W-1:0]          out_data_q;
	logic [frapq_pkg::TREE_AW-1:0]        clr_q;

	logic                                 rd_pend_s1;
	logic                                 sum_pend_s1;
	logic [frapq_pkg::TREE_AW-1:0]        wr_addr_s1;
	logic [frapq_pkg::SUM_W-1:0]          rd_data_s1;

	logic [frapq_pkg::TREE_AW-1:0]        rd_addr;
	logic [frapq_pkg::IDX_W-1:0]          right_p1;
	logic [frapq_pkg::IDX_W-1:0]          size_x;
	logic [frapq_pkg::IDX_W-1:0]          step;
	logic                                 up_read;
	logic                                 down_read;

	assign size_x    = frapq_pkg::IDX_W'(size_eff);
	assign right_p1  = frapq_pkg::IDX_W'(right_q) + frapq_pkg::IDX_W'(1);
	assign rd_addr   = frapq_pkg::TREE_AW'(idx_q - frapq_pkg::IDX_W'(1));
	assign step      = frapq_pkg::low_bit(idx_q);
	assign up_read   = cmd.up_step && !status.up_done;
	assign down_read = cmd.down_step && !status.down_done;
	assign out_value = out_data_q;

	always_comb begin
		status.mode      = mode_q;
		status.load_ok   = (load_pos_q <= size_eff);
		status.left_ok   = (left_q != '0) && (left_q <= size_eff);
		status.right_ok  = (right_p1 <= size_x);
		status.up_done   = (idx_q > size_x);
		status.down_done = (idx_q == '0);
		status.clr_last  = (clr_q == frapq_pkg::TREE_AW'(frapq_pkg::MAX_ELEMENTS - 1));
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= tree_mem[rd_addr];
		if (cmd.clr_step) begin
			tree_mem[clr_q] <= '0;
		end else if (rd_pend_s1) begin
			tree_mem[wr_addr_s1] <= rd_data_s1 + delta_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q  <= frapq_pkg::POS_W'(1);
			prev_q      <= '0;
			clr_q       <= '0;
			rd_pend_s1  <= 1'b0;
			sum_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1  <= up_read;
			sum_pend_s1 <= down_read;
			if (cmd.clr_step) begin
				clr_q <= clr_q + frapq_pkg::TREE_AW'(1);
			end
			if (cmd.start_load) begin
				prev_q     <= value_q;
				load_pos_q <= load_pos_q + frapq_pkg::POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q  <= in_mode;
			left_q  <= in_left;
			right_q <= in_right;
			value_q <= in_value;
		end
		if (up_read) begin
			wr_addr_s1 <= rd_addr;
		end
		if (cmd.start_load) begin
			idx_q   <= frapq_pkg::IDX_W'(load_pos_q);
			delta_q <= frapq_pkg::SUM_W'(value_q) - frapq_pkg::SUM_W'(prev_q);
		end else if (cmd.start_left) begin
			idx_q   <= frapq_pkg::IDX_W'(left_q);
			delta_q <= frapq_pkg::SUM_W'(value_q);
		end else if (cmd.start_right) begin
			idx_q   <= right_p1;
			delta_q <= '0 - frapq_pkg::SUM_W'(value_q);
		end else if (cmd.start_query) begin
			idx_q <= (left_q > size_eff) ? size_x : frapq_pkg::IDX_W'(left_q);
		end else if (up_read) begin
			idx_q <= idx_q + step;
		end else if (down_read) begin
			idx_q <= idx_q - step;
		end
		if (cmd.start_query) begin
			acc_q <= '0;
		end else if (sum_pend_s1) begin
			acc_q <= acc_q + rd_data_s1;
		end
		if (cmd.out_load) begin
			out_data_q <= acc_q;
		end
	end

endmodule
